@@ design/assert_macros.svh @@
// assertion macros shared by the checker files
// no dependencies; every macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/upsc_pkg.sv @@
// shared types and constants for the ultrasonic ranging / stepper sequencer
// no dependencies; imported by every module of the block
package upsc_pkg;

    localparam int TIMER_W = 20;
    localparam int ECHO_W  = 16;
    localparam int TRIG_W  = 10;
    localparam int STEP_W  = 8;
    localparam int COIL_W  = 4;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
    localparam logic [ECHO_W-1:0]  ECHO_MAX  = {ECHO_W{1'b1}};

    localparam logic [COIL_W-1:0] COIL_FIRST = 4'b0001;
    localparam logic [COIL_W-1:0] COIL_LAST  = 4'b1000;

    typedef enum logic [2:0] {
        PH_TRIG  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_COUNT = 3'd2,
        PH_FWD   = 3'd3,
        PH_PAUSE = 3'd4,
        PH_REV   = 3'd5,
        PH_IDLE  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        REG_TRIGGER = 3'd0,
        REG_NEAR    = 3'd1,
        REG_HOLD    = 3'd2,
        REG_STEPS   = 3'd3,
        REG_PAUSE   = 3'd4,
        REG_IDLE    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [TRIG_W-1:0]  trigger_ticks;
        logic [ECHO_W-1:0]  near_echo_ticks;
        logic [TIMER_W-1:0] step_hold_ticks;
        logic [STEP_W-1:0]  steps_per_direction;
        logic [TIMER_W-1:0] pause_ticks;
        logic [TIMER_W-1:0] idle_ticks;
    } upsc_cfg_t;

    typedef struct packed {
        logic              trigger_out;
        logic [COIL_W-1:0] coil_pattern;
        logic              measure_done;
        logic [ECHO_W-1:0] echo_width;
        logic              object_near;
    } upsc_res_t;

endpackage

@@ design/upsc_regs.sv @@
// configuration register file behind the apb-style port
// depends on upsc_pkg for register indexes and the configuration struct
module upsc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [upsc_pkg::ADDR_W-1:0] paddr,
    input  logic [upsc_pkg::DATA_W-1:0] pwdata,
    output logic [upsc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output upsc_pkg::upsc_cfg_t         cfg
);
    import upsc_pkg::*;

    upsc_cfg_t cfg_reg;
    reg_idx_t  idx;
    logic      wr_en;

    assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks       <= TRIG_W'(10);
            cfg_reg.near_echo_ticks     <= ECHO_W'(1166);
            cfg_reg.step_hold_ticks     <= TIMER_W'(3000);
            cfg_reg.steps_per_direction <= STEP_W'(48);
            cfg_reg.pause_ticks         <= TIMER_W'(100000);
            cfg_reg.idle_ticks          <= TIMER_W'(1000000);
        end
        else if (wr_en)
        begin
            // indexes past the last register are ignored
            unique case (idx)
                REG_TRIGGER: cfg_reg.trigger_ticks       <= pwdata[TRIG_W-1:0];
                REG_NEAR:    cfg_reg.near_echo_ticks     <= pwdata[ECHO_W-1:0];
                REG_HOLD:    cfg_reg.step_hold_ticks     <= pwdata[TIMER_W-1:0];
                REG_STEPS:   cfg_reg.steps_per_direction <= pwdata[STEP_W-1:0];
                REG_PAUSE:   cfg_reg.pause_ticks         <= pwdata[TIMER_W-1:0];
                REG_IDLE:    cfg_reg.idle_ticks          <= pwdata[TIMER_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TRIGGER: prdata = DATA_W'(cfg_reg.trigger_ticks);
            REG_NEAR:    prdata = DATA_W'(cfg_reg.near_echo_ticks);
            REG_HOLD:    prdata = DATA_W'(cfg_reg.step_hold_ticks);
            REG_STEPS:   prdata = DATA_W'(cfg_reg.steps_per_direction);
            REG_PAUSE:   prdata = DATA_W'(cfg_reg.pause_ticks);
            REG_IDLE:    prdata = DATA_W'(cfg_reg.idle_ticks);
            default:     prdata = '0;
        endcase
    end

endmodule

@@ design/upsc_seq.sv @@
// phase sequencer: trigger, echo wait and count, forward run, pause, reverse run, idle
// depends on upsc_pkg; state moves one tick on each accepted transfer
module upsc_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 echo_level,
    input  upsc_pkg::upsc_cfg_t  cfg,
    output upsc_pkg::upsc_res_t  res
);
    import upsc_pkg::*;

    phase_t             phase_reg,   phase_next;
    logic [TIMER_W-1:0] timer_reg,   timer_next;
    logic [ECHO_W-1:0]  echo_cnt_reg, echo_cnt_next;
    logic [STEP_W-1:0]  step_reg,    step_next;
    logic [COIL_W-1:0]  coil_reg,    coil_next;
    logic               near_reg,    near_next;

    logic [TIMER_W-1:0] timer_inc;
    logic [TIMER_W-1:0] duration;
    logic               elapsed;
    logic [STEP_W-1:0]  step_inc;
    logic               run_end;
    logic               near_now;

    // saturating timer shared by every timed phase
    assign timer_inc = (timer_reg < TIMER_MAX) ? timer_reg + TIMER_W'(1) : timer_reg;

    always_comb
    begin
        case (phase_reg)
            PH_TRIG:         duration = TIMER_W'(cfg.trigger_ticks);
            PH_FWD, PH_REV:  duration = cfg.step_hold_ticks;
            PH_PAUSE:        duration = cfg.pause_ticks;
            default:         duration = cfg.idle_ticks;
        endcase
    end

    // a zero duration ends after one tick because timer_inc is at least one
    assign elapsed  = (timer_inc >= duration) || (timer_inc == TIMER_MAX);
    assign step_inc = step_reg + STEP_W'(1);
    // zero steps per direction still drives one step
    assign run_end  = (step_inc >= cfg.steps_per_direction) || (step_inc == '0);
    assign near_now = TIMER_W'(cfg.near_echo_ticks) > timer_reg;

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        echo_cnt_next = echo_cnt_reg;
        step_next     = step_reg;
        coil_next     = coil_reg;
        near_next     = near_reg;
        unique case (phase_reg)
            PH_TRIG:
            begin
                timer_next = timer_inc;
                if (elapsed)
                begin
                    phase_next = PH_WAIT;
                    timer_next = '0;
                end
            end
            PH_WAIT:
            begin
                if (echo_level)
                begin
                    phase_next = PH_COUNT;
                    timer_next = TIMER_W'(1);
                end
            end
            PH_COUNT:
            begin
                if (echo_level)
                begin
                    if (timer_reg < TIMER_W'(ECHO_MAX))
                        timer_next = timer_reg + TIMER_W'(1);
                end
                else
                begin
                    echo_cnt_next = timer_reg[ECHO_W-1:0];
                    near_next     = near_now;
                    timer_next    = '0;
                    step_next     = '0;
                    if (near_now)
                    begin
                        phase_next = PH_FWD;
                        coil_next  = COIL_FIRST;
                    end
                    else
                        phase_next = PH_IDLE;
                end
            end
            PH_FWD, PH_REV:
            begin
                timer_next = timer_inc;
                if (elapsed)
                begin
                    timer_next = '0;
                    step_next  = step_inc;
                    if (run_end)
                    begin
                        step_next  = '0;
                        phase_next = (phase_reg == PH_FWD) ? PH_PAUSE : PH_IDLE;
                    end
                    else if (phase_reg == PH_FWD)
                        coil_next = COIL_FIRST << step_inc[1:0];
                    else
                        coil_next = COIL_LAST >> step_inc[1:0];
                end
            end
            PH_PAUSE:
            begin
                timer_next = timer_inc;
                if (elapsed)
                begin
                    phase_next = PH_REV;
                    timer_next = '0;
                    step_next  = '0;
                    coil_next  = COIL_LAST;
                end
            end
            PH_IDLE:
            begin
                timer_next = timer_inc;
                if (elapsed)
                begin
                    phase_next = PH_TRIG;
                    timer_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_TRIG;
                timer_next = '0;
            end
        endcase
    end

    // result of the current tick
    always_comb
    begin
        res.trigger_out  = (phase_reg == PH_TRIG);
        res.coil_pattern = coil_reg;
        res.measure_done = (phase_reg == PH_COUNT) && !echo_level;
        res.echo_width   = res.measure_done ? timer_reg[ECHO_W-1:0] : echo_cnt_reg;
        res.object_near  = res.measure_done ? near_now : near_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TRIG;
            timer_reg    <= '0;
            echo_cnt_reg <= '0;
            step_reg     <= '0;
            coil_reg     <= '0;
            near_reg     <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            echo_cnt_reg <= echo_cnt_next;
            step_reg     <= step_next;
            coil_reg     <= coil_next;
            near_reg     <= near_next;
        end
    end

endmodule

@@ design/ultrasonic_proximity_stepper_cycle.sv @@
// Ultrasonic ranging with a four-coil stepper in wave drive.
// Input channel (in_valid, in_stall, echo_level): one transfer per microsecond
// tick carrying the sampled echo pin. Output channel (out_valid, out_stall,
// trigger_out, coil_pattern, measure_done, echo_width, object_near): exactly
// one result per input transfer, in order.
// A result is in the output register on the cycle after its input transfer.
// Throughput is one transfer per cycle while no stall is raised; the phase update
// is a single pass of counter, compare and select logic between the state
// registers and the output register.
// in_stall is raised only while a result sits in the output register and the
// receiver stalls it; the result then holds until it is taken, and a new
// input can be taken in the same cycle the old result leaves.
// Reset (rst_n low, asynchronous) empties the output register, returns the
// sequencer to the trigger phase with all counters and coils cleared, and
// loads the default register values. Registers are written through the apb
// port, by the user only while no transfer is in flight; the block does not enforce it.
// depends on upsc_pkg, upsc_regs and upsc_seq
module ultrasonic_proximity_stepper_cycle (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [upsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [upsc_pkg::DATA_W-1:0]   pwdata,
    output logic [upsc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          echo_level,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          trigger_out,
    output logic [upsc_pkg::COIL_W-1:0]   coil_pattern,
    output logic                          measure_done,
    output logic [upsc_pkg::ECHO_W-1:0]   echo_width,
    output logic                          object_near
);
    import upsc_pkg::*;

    upsc_cfg_t cfg;
    upsc_res_t res;
    upsc_res_t res_reg;
    logic      out_valid_reg;
    logic      advance;

    upsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    upsc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .echo_level (echo_level),
        .cfg        (cfg),
        .res        (res)
    );

    assign in_stall = out_valid_reg && out_stall;
    assign advance  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!in_stall)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign trigger_out  = res_reg.trigger_out;
    assign coil_pattern = res_reg.coil_pattern;
    assign measure_done = res_reg.measure_done;
    assign echo_width   = res_reg.echo_width;
    assign object_near  = res_reg.object_near;

endmodule

@@ design/upsc_chk.sv @@
// port-level checker for the ranging / stepper block, bound to the top level
// depends on assert_macros.svh and upsc_pkg for widths
`include "assert_macros.svh"

module upsc_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        trigger_out,
    input logic [upsc_pkg::COIL_W-1:0] coil_pattern,
    input logic                        measure_done
);
    import upsc_pkg::*;

    // every accepted transfer shows a result on the next cycle
    `ASSERT_NEXT(a_latency, in_valid && !in_stall, out_valid, "result missing after transfer")

    // a held result is not dropped while the receiver stalls
    `ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid, "stalled result dropped")

    // wave drive never energises two coils at once
    `ASSERT_IMPL(a_coil, out_valid, $onehot0(coil_pattern), "more than one coil driven")

    // a measurement never completes while the trigger is driven
    `ASSERT_IMPL(a_done_trig, out_valid && measure_done, !trigger_out,
        "measurement done during trigger")

endmodule

bind ultrasonic_proximity_stepper_cycle upsc_chk u_upsc_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .trigger_out  (trigger_out),
    .coil_pattern (coil_pattern),
    .measure_done (measure_done)
);
